// ===== hw/rtl/lfu_pkg.sv =====
package lfu_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 31;
    localparam int USE_W  = 16;
    localparam int LCAP_W = 5;

    localparam logic [USE_W-1:0]  USES_MAX = 16'hFFFF;
    localparam logic [LCAP_W-1:0] LCAP_RST = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_rsp;

endpackage

// ===== hw/rtl/lfu_req_if.sv =====
interface lfu_req_if
    import lfu_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

// ===== hw/rtl/lfu_rsp_if.sv =====
interface lfu_rsp_if
    import lfu_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

// ===== hw/rtl/lfu_entry_mem.sv =====
module lfu_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 83,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lfu_seq.sv =====
module lfu_seq
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int EW = KEY_W + VAL_W + USE_W + IW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfu_req_if.sink       i_req,
    input  logic [CW-1:0] i_cap,
    output logic          o_res_valid,
    output t_rsp          o_res,
    input  logic          i_res_take,
    output logic          o_mem_we,
    output logic [IW-1:0] o_mem_waddr,
    output logic [EW-1:0] o_mem_wdata,
    output logic [IW-1:0] o_mem_raddr,
    input  logic [EW-1:0] i_mem_rdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    // control
    logic [2:0]          r_state;
    logic [IW-1:0]       r_idx;
    logic                r_iss;
    logic                r_pend;
    logic [IW-1:0]       r_pidx;
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [CW-1:0]       r_occ;
    logic                r_found;
    logic                r_vfound;
    logic                r_free_ok;

    // request and scan results
    logic             r_func;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IW-1:0]    r_fidx;
    logic [VAL_W-1:0] r_fdata;
    logic [IW-1:0]    r_fage;
    logic [IW-1:0]    r_vidx;
    logic [USE_W-1:0] r_vuses;
    logic [IW-1:0]    r_vage;
    logic [KEY_W-1:0] r_vkey;
    logic [IW-1:0]    r_fridx;
    logic             r_bump;
    logic             r_evict;
    logic [IW-1:0]    r_slot;
    logic [IW-1:0]    r_aold;
    t_rsp             r_res;

    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_data;
    logic [USE_W-1:0] e_uses;
    logic [IW-1:0]    e_age;
    logic             e_vld;

    logic s_match, s_better, s_free, s_last;
    logic d_cap0, d_evict, d_ins_ok, d_ins, d_upd;
    logic [IW-1:0] d_slot;
    logic w_slot;
    logic [IW-1:0]    w_age;
    logic [USE_W-1:0] w_uses;
    logic [VAL_W-1:0] w_data;
    logic [KEY_W-1:0] w_key;

    assign e_key  = i_mem_rdata[EW-1 -: KEY_W];
    assign e_data = i_mem_rdata[IW+USE_W +: VAL_W];
    assign e_uses = i_mem_rdata[IW +: USE_W];
    assign e_age  = i_mem_rdata[IW-1:0];
    assign e_vld  = r_valid[r_pidx];

    assign s_last   = r_pend && (r_pidx == LAST);
    assign s_match  = r_pend && e_vld && (e_key == r_key) && !r_found;
    // lowest count wins, oldest among equal counts
    assign s_better = r_pend && e_vld &&
                      (!r_vfound || (e_uses < r_vuses) ||
                       ((e_uses == r_vuses) && (e_age > r_vage)));
    assign s_free   = r_pend && !e_vld && !r_free_ok;

    always_comb begin
        d_cap0   = (i_cap == '0);
        d_evict  = r_vfound && (r_occ >= i_cap);
        d_slot   = (d_evict && (!r_free_ok || (r_vidx < r_fridx))) ? r_vidx : r_fridx;
        d_ins_ok = d_evict || r_free_ok;
        d_ins    = (r_func == FUNC_PUT) && !d_cap0 && !r_found && d_ins_ok;
        if (r_func == FUNC_GET) begin
            d_upd = r_found;
        end else begin
            d_upd = !d_cap0 && (r_found || d_ins_ok);
        end
    end

    // valid bits after an insert, victim dropped first
    always_comb begin
        n_valid = r_valid;
        if (d_evict) begin
            n_valid[r_vidx] = 1'b0;
        end
        n_valid[d_slot] = 1'b1;
    end

    // write-back of one entry during the update pass
    always_comb begin
        w_slot = (r_pidx == r_slot);
        if (w_slot) begin
            w_age = '0;
        end else if (r_bump) begin
            w_age = (e_age < r_aold) ? e_age + IW'(1) : e_age;
        end else begin
            w_age = (r_evict && (e_age > r_vage)) ? e_age : e_age + IW'(1);
        end
        if (!w_slot) begin
            w_uses = e_uses;
        end else if (r_bump) begin
            w_uses = (e_uses == USES_MAX) ? e_uses : e_uses + USE_W'(1);
        end else begin
            w_uses = USE_W'(1);
        end
        w_data = (w_slot && (r_func == FUNC_PUT)) ? r_value : e_data;
        w_key  = w_slot ? r_key : e_key;
    end

    assign o_mem_raddr = r_idx;
    assign o_mem_waddr = r_pidx;
    assign o_mem_wdata = {w_key, w_data, w_uses, w_age};
    assign o_mem_we    = (r_state == ST_UPD) && r_pend && (w_slot || e_vld);

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_iss     <= 1'b0;
            r_pend    <= 1'b0;
            r_pidx    <= '0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_found   <= 1'b0;
            r_vfound  <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            // read issue shared by both passes
            if (r_iss) begin
                r_pend <= 1'b1;
                r_pidx <= r_idx;
                if (r_idx == LAST) begin
                    r_iss <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end else begin
                r_pend <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_state   <= ST_SCAN;
                        r_idx     <= '0;
                        r_iss     <= 1'b1;
                        r_found   <= 1'b0;
                        r_vfound  <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (s_match) begin
                        r_found <= 1'b1;
                    end
                    if (s_better) begin
                        r_vfound <= 1'b1;
                    end
                    if (s_free) begin
                        r_free_ok <= 1'b1;
                    end
                    if (s_last) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (d_ins) begin
                        r_valid <= n_valid;
                        if (!d_evict) begin
                            r_occ <= r_occ + CW'(1);
                        end
                    end
                    if (d_upd) begin
                        r_state <= ST_UPD;
                        r_idx   <= '0;
                        r_iss   <= 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_UPD: begin
                    if (s_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_res_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_req.valid) begin
            r_func  <= i_req.func;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (r_state == ST_SCAN) begin
            if (s_match) begin
                r_fidx  <= r_pidx;
                r_fdata <= e_data;
                r_fage  <= e_age;
            end
            if (s_better) begin
                r_vidx  <= r_pidx;
                r_vuses <= e_uses;
                r_vage  <= e_age;
                r_vkey  <= e_key;
            end
            if (s_free) begin
                r_fridx <= r_pidx;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_bump  <= r_found;
            r_evict <= d_ins && d_evict;
            r_slot  <= r_found ? r_fidx : d_slot;
            r_aold  <= r_fage;
            r_res.hit         <= r_found;
            r_res.read_value  <= ((r_func == FUNC_GET) && r_found) ? r_fdata : '0;
            r_res.evicted     <= d_ins && d_evict;
            r_res.evicted_key <= (d_ins && d_evict) ? r_vkey : '0;
        end
    end

endmodule

// ===== hw/rtl/lfu_cache_lru_tiebreak.sv =====
// Channel  Dir  Handshake     Payload
// i_req    in   valid/ready   func, key, value
// o_rsp    out  valid/ready   hit, read_value, evicted, evicted_key
// i_cfg    in   we only       live_capacity (5 bits)
//
// One request at a time. A request takes a scan pass over all CAPACITY entries
// of the entry memory (one read a cycle), a decision state, and, when state
// changes, an update pass over all CAPACITY entries; a get miss or a refused
// put skips the update pass.
// Reset clears the valid bits and occupancy; entry memory contents need no clear.
// The response register frees the engine: a new request is taken while o_rsp stalls.
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lfu_req_if.sink           i_req,
    lfu_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic [LCAP_W-1:0] i_cfg_wdata
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_W + VAL_W + USE_W + IW;
    localparam int MW = (CW > LCAP_W) ? CW : LCAP_W;

    logic [LCAP_W-1:0] r_live;
    logic [CW-1:0]     cap;
    logic              r_ov;
    t_rsp              r_out;
    logic              res_valid;
    t_rsp              res;
    logic              res_take;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [EW-1:0]     mem_wdata;
    logic [IW-1:0]     mem_raddr;
    logic [EW-1:0]     mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= LCAP_RST;
        end else if (i_cfg_we) begin
            r_live <= i_cfg_wdata;
        end
    end

    // clamp to the physical entry count
    assign cap = (MW'(r_live) > MW'(CAPACITY)) ? CW'(CAPACITY) : CW'(r_live);

    assign res_take = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_take) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.hit         = r_out.hit;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.evicted     = r_out.evicted;
    assign o_rsp.evicted_key = r_out.evicted_key;

    lfu_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cap       (cap),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    lfu_entry_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
